// File: rtl/max_flow_augmenting_path_assert.svh
// Assertion macros for the max flow RTL.
// Included by modules that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef MAX_FLOW_AUGMENTING_PATH_ASSERT_SVH
`define MAX_FLOW_AUGMENTING_PATH_ASSERT_SVH
`ifndef SYNTHESIS
`define MFAP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("mfap assertion failed");
`define MFAP_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("mfap forbidden condition");
`else
`define MFAP_ASSERT(lbl, prop)
`define MFAP_NEVER(lbl, cond)
`endif
`endif

// File: rtl/mfap_pkg.sv
// Shared constants and types of the max flow block.
// No dependencies.
`default_nettype none
package mfap_pkg;
  localparam int MAX_VERTICES_DEF = 128;
  localparam int MAX_EDGES_DEF    = 1024;
  localparam int CAP_WIDTH_DEF    = 16;

  // Largest amount pushed along one path.
  localparam logic [30:0] PATH_LIMIT = 31'h4000_0000;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_SOLVE = 1'b1;

  localparam logic [1:0] ST_EDGE_OK = 2'd0;
  localparam logic [1:0] ST_RESULT  = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  // Controls from the sequencer to the edge store.
  typedef struct packed {
    logic wr_en;
    logic flow_wr_en;
    logic rd_en;
  } edge_ctl_t;
endpackage
`default_nettype wire

// File: rtl/mfap_if.sv
// Valid/ready channel interfaces for the input items and the results.
// No dependencies.
`default_nettype none
interface mfap_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [6:0]  edge_tail;
  logic [6:0]  edge_head;
  logic [15:0] edge_capacity;
  modport source(output valid, opcode, edge_tail, edge_head, edge_capacity, input ready);
  modport sink(input valid, opcode, edge_tail, edge_head, edge_capacity, output ready);
endinterface

interface mfap_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] max_flow;
  modport source(output valid, status, max_flow, input ready);
  modport sink(input valid, status, max_flow, output ready);
endinterface
`default_nettype wire

// File: rtl/mfap_edge_store.sv
// Edge memory (tail, head, capacity) and flow memory with one registered read port.
// Depends on mfap_pkg.
`default_nettype none
module mfap_edge_store #(
  parameter int MAX_EDGES = mfap_pkg::MAX_EDGES_DEF,
  parameter int CAP_WIDTH = mfap_pkg::CAP_WIDTH_DEF,
  parameter int EW        = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
  input  wire logic                  clk_i,
  input  wire mfap_pkg::edge_ctl_t   ctl_i,
  input  wire logic [EW-1:0]         waddr_i,
  input  wire logic [6:0]            tail_i,
  input  wire logic [6:0]            head_i,
  input  wire logic [CAP_WIDTH-1:0]  cap_i,
  input  wire logic [EW-1:0]         flow_waddr_i,
  input  wire logic [CAP_WIDTH-1:0]  flow_i,
  input  wire logic [EW-1:0]         raddr_i,
  output logic [6:0]                 tail_o,
  output logic [6:0]                 head_o,
  output logic [CAP_WIDTH-1:0]       cap_o,
  output logic [CAP_WIDTH-1:0]       flow_o
);
  logic [CAP_WIDTH+13:0] edge_mem [MAX_EDGES];
  logic [CAP_WIDTH-1:0]  flow_mem [MAX_EDGES];
  logic [CAP_WIDTH+13:0] edge_rd_q;
  logic [CAP_WIDTH-1:0]  flow_rd_q;

  // Edge words are written once when an edge is added.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      edge_mem[waddr_i] <= {tail_i, head_i, cap_i};
    end
    if (ctl_i.rd_en) begin
      edge_rd_q <= edge_mem[raddr_i];
    end
  end

  // Flows start at zero on add and change on every augmentation.
  always_ff @(posedge clk_i) begin
    if (ctl_i.flow_wr_en) begin
      flow_mem[flow_waddr_i] <= flow_i;
    end
    if (ctl_i.rd_en) begin
      flow_rd_q <= flow_mem[raddr_i];
    end
  end

  assign tail_o = edge_rd_q[CAP_WIDTH+13:CAP_WIDTH+7];
  assign head_o = edge_rd_q[CAP_WIDTH+6:CAP_WIDTH];
  assign cap_o  = edge_rd_q[CAP_WIDTH-1:0];
  assign flow_o = flow_rd_q;
endmodule
`default_nettype wire

// File: rtl/mfap_search_stack.sv
// Depth-first search stack memory, one write and one registered read per cycle.
// Depends on nothing but its parameters.
`default_nettype none
module mfap_search_stack #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int SW    = 33
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [SW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic [SW-1:0]      rdata_o
);
  logic [SW-1:0] mem [DEPTH];
  logic [SW-1:0] rdata_q;

  // Frames are pushed on descent and read back on pop and path walks.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

// File: rtl/mfap_alu.sv
// Shared residual unit: residual, threshold test, running minimum and flow update.
// Depends on nothing but its parameters.
`default_nettype none
module mfap_alu #(
  parameter int CAP_WIDTH = 16
) (
  input  wire logic [CAP_WIDTH-1:0] cap_i,
  input  wire logic [CAP_WIDTH-1:0] flow_i,
  input  wire logic                 back_i,
  input  wire logic [30:0]          thr_i,
  input  wire logic [30:0]          bneck_i,
  output logic                      pass_o,
  output logic [30:0]               min_o,
  output logic [CAP_WIDTH-1:0]      flow_o
);
  logic [CAP_WIDTH-1:0] resid;
  logic [31:0]          resid_w;

  // Forward residual is free capacity; backward residual is the flow to cancel.
  assign resid   = back_i ? flow_i : cap_i - flow_i;
  assign resid_w = 32'(resid);
  assign pass_o  = resid_w >= {1'b0, thr_i};
  assign min_o   = (resid_w < {1'b0, bneck_i}) ? resid_w[30:0] : bneck_i;
  assign flow_o  = back_i ? flow_i - CAP_WIDTH'(bneck_i) : flow_i + CAP_WIDTH'(bneck_i);
endmodule
`default_nettype wire

// File: rtl/max_flow_augmenting_path.sv
// Top level of the max flow block: sequencer around the edge store, stack and residual unit.
// Depends on mfap_pkg, mfap_if, mfap_edge_store, mfap_search_stack, mfap_alu.
//
// Channel   Direction  Contents
// in_i      sink       opcode, edge_tail, edge_head, edge_capacity
// out_o     source     status, max_flow
// cfg       write      cfg_we_i, cfg_wdata_i (num_vertices)
//
// An add item is handled in IDLE; its result sits in the output register, and the next item
// is taken in the same cycle that result leaves, so adds flow at one item per cycle while
// the output is not stalled. A solve item runs repeated depth-first searches: an edge scan
// passes CHECK and EDGE, a pop CHECK and POP, a path edge WRD, WE, WR for the bottleneck and
// URD, UE, UW to update flows; the single read port of the edge store sets this pace.
// Reset is asynchronous and clears control state only; no clearing pass is needed.
// A stalled output holds the result and the block takes no item until it leaves.
`default_nettype none
`include "max_flow_augmenting_path_assert.svh"
module max_flow_augmenting_path #(
  parameter int MAX_VERTICES = mfap_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = mfap_pkg::MAX_EDGES_DEF,
  parameter int CAP_WIDTH    = mfap_pkg::CAP_WIDTH_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  mfap_in_if.sink     in_i,
  mfap_out_if.source  out_o,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i
);
  localparam int VW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int NVW = $clog2(MAX_VERTICES + 1);
  localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW  = $clog2(MAX_EDGES + 1);
  localparam int SW  = VW + CW + EW + 1;
  localparam logic [30:0] THR_INIT = (CAP_WIDTH - 1 >= 30) ? mfap_pkg::PATH_LIMIT
                                     : 31'(64'd1 << (CAP_WIDTH - 1));

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_INIT  = 13'b0000000000010,
    S_CHECK = 13'b0000000000100,
    S_EDGE  = 13'b0000000001000,
    S_POP   = 13'b0000000010000,
    S_SAVE  = 13'b0000000100000,
    S_WRD   = 13'b0000001000000,
    S_WE    = 13'b0000010000000,
    S_WR    = 13'b0000100000000,
    S_URD   = 13'b0001000000000,
    S_UE    = 13'b0010000000000,
    S_UW    = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_e;

  state_e                state_q, state_d;
  logic [7:0]            nv_cfg_q;
  logic [NVW-1:0]        nv_q, nv_d, nv_clamp;
  logic [30:0]           thr_q, thr_d;
  logic [31:0]           total_q, total_d;
  logic [CW-1:0]         count_q, count_d;
  logic [MAX_VERTICES-1:0] vis_q, vis_d;
  logic [VW-1:0]         top_q, top_d;
  logic [VW-1:0]         cur_v_q, cur_v_d;
  logic [CW-1:0]         cur_n_q, cur_n_d;
  logic [EW-1:0]         cur_e_q, cur_e_d;
  logic                  cur_b_q, cur_b_d;
  logic [EW-1:0]         e_q, e_d;
  logic [VW-1:0]         k_q, k_d;
  logic [30:0]           b_q, b_d;
  logic                  ov_q, ov_d;
  logic [1:0]            ost_q, ost_d;
  logic [31:0]           oflow_q, oflow_d;

  mfap_pkg::edge_ctl_t   ectl;
  logic [EW-1:0]         e_raddr;
  logic [6:0]            rd_tail, rd_head;
  logic [CAP_WIDTH-1:0]  rd_cap, rd_flow;
  logic                  s_we, s_re;
  logic [VW-1:0]         s_waddr, s_raddr;
  logic [SW-1:0]         s_wdata, s_rdata;
  logic [VW-1:0]         sr_v;
  logic [CW-1:0]         sr_n;
  logic [EW-1:0]         sr_e;
  logic                  sr_b;
  logic                  alu_back, alu_pass;
  logic [30:0]           alu_min;
  logic [CAP_WIDTH-1:0]  alu_flow;
  logic                  in_xfer, out_free;
  logic [VW-1:0]         sink_v, tail_v, head_v;
  logic                  tail_ok, head_ok, fwd, bwd;
  logic [32:0]           sum;

  assign {sr_v, sr_n, sr_e, sr_b} = s_rdata;
  assign s_wdata  = {cur_v_q, cur_n_q, cur_e_q, cur_b_q};
  assign out_free = !ov_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE) && out_free;
  assign in_xfer  = in_i.valid && in_i.ready;

  // Clamp the configured vertex count into the legal range.
  always_comb begin
    if (nv_cfg_q < 8'd2) begin
      nv_clamp = NVW'(2);
    end else if (32'(nv_cfg_q) > MAX_VERTICES) begin
      nv_clamp = NVW'(MAX_VERTICES);
    end else begin
      nv_clamp = NVW'(nv_cfg_q);
    end
  end

  // Edge candidate tests against the vertex on top of the stack.
  assign sink_v  = VW'(nv_q - NVW'(1));
  assign tail_v  = VW'(rd_tail);
  assign head_v  = VW'(rd_head);
  assign tail_ok = 32'(rd_tail) < 32'(nv_q);
  assign head_ok = 32'(rd_head) < 32'(nv_q);
  assign fwd = tail_ok && (tail_v == cur_v_q) && head_ok && !vis_q[head_v] && alu_pass;
  assign bwd = !(tail_ok && tail_v == cur_v_q) && head_ok && (head_v == cur_v_q)
               && tail_ok && !vis_q[tail_v] && alu_pass;
  assign alu_back = (state_q == S_EDGE) ? !(tail_ok && tail_v == cur_v_q) : sr_b;
  assign sum = 33'(total_q) + 33'(b_q);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    nv_d    = nv_q;
    thr_d   = thr_q;
    total_d = total_q;
    count_d = count_q;
    vis_d   = vis_q;
    top_d   = top_q;
    cur_v_d = cur_v_q;
    cur_n_d = cur_n_q;
    cur_e_d = cur_e_q;
    cur_b_d = cur_b_q;
    e_d     = e_q;
    k_d     = k_q;
    b_d     = b_q;
    ov_d    = ov_q && !out_o.ready;
    ost_d   = ost_q;
    oflow_d = oflow_q;
    ectl    = '0;
    e_raddr = EW'(cur_n_q);
    s_we    = 1'b0;
    s_re    = 1'b0;
    s_waddr = top_q;
    s_raddr = k_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_i.opcode == mfap_pkg::OP_ADD) begin
            ov_d    = 1'b1;
            oflow_d = '0;
            if (32'(count_q) >= MAX_EDGES) begin
              ost_d = mfap_pkg::ST_FULL;
            end else begin
              ost_d            = mfap_pkg::ST_EDGE_OK;
              ectl.wr_en       = 1'b1;
              ectl.flow_wr_en  = 1'b1;
              count_d          = count_q + CW'(1);
            end
          end else begin
            nv_d    = nv_clamp;
            thr_d   = THR_INIT;
            total_d = '0;
            state_d = S_INIT;
          end
        end
      end
      S_INIT: begin
        vis_d    = '0;
        vis_d[0] = 1'b1;
        cur_v_d  = '0;
        cur_n_d  = '0;
        top_d    = '0;
        state_d  = S_CHECK;
      end
      S_CHECK: begin
        if (cur_v_q == sink_v) begin
          state_d = S_SAVE;
        end else if (cur_n_q < count_q) begin
          ectl.rd_en = 1'b1;
          e_d        = EW'(cur_n_q);
          cur_n_d    = cur_n_q + CW'(1);
          state_d    = S_EDGE;
        end else if (top_q == '0) begin
          thr_d   = thr_q >> 1;
          state_d = ((thr_q >> 1) == '0) ? S_DONE : S_INIT;
        end else begin
          s_re    = 1'b1;
          s_raddr = top_q - VW'(1);
          state_d = S_POP;
        end
      end
      S_EDGE: begin
        if (fwd || bwd) begin
          s_we    = 1'b1;
          vis_d[fwd ? head_v : tail_v] = 1'b1;
          cur_v_d = fwd ? head_v : tail_v;
          cur_n_d = '0;
          cur_e_d = e_q;
          cur_b_d = bwd;
          top_d   = top_q + VW'(1);
        end
        state_d = S_CHECK;
      end
      S_POP: begin
        cur_v_d = sr_v;
        cur_n_d = sr_n;
        cur_e_d = sr_e;
        cur_b_d = sr_b;
        top_d   = top_q - VW'(1);
        state_d = S_CHECK;
      end
      S_SAVE: begin
        s_we    = 1'b1;
        k_d     = VW'(1);
        b_d     = mfap_pkg::PATH_LIMIT;
        state_d = S_WRD;
      end
      S_WRD: begin
        s_re    = 1'b1;
        state_d = S_WE;
      end
      S_WE: begin
        ectl.rd_en = 1'b1;
        e_raddr    = sr_e;
        state_d    = S_WR;
      end
      S_WR: begin
        b_d = alu_min;
        if (k_q == top_q) begin
          k_d     = VW'(1);
          state_d = S_URD;
        end else begin
          k_d     = k_q + VW'(1);
          state_d = S_WRD;
        end
      end
      S_URD: begin
        s_re    = 1'b1;
        state_d = S_UE;
      end
      S_UE: begin
        ectl.rd_en = 1'b1;
        e_raddr    = sr_e;
        state_d    = S_UW;
      end
      S_UW: begin
        ectl.flow_wr_en = 1'b1;
        if (k_q == top_q) begin
          total_d = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          state_d = S_INIT;
        end else begin
          k_d     = k_q + VW'(1);
          state_d = S_URD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          ov_d    = 1'b1;
          ost_d   = mfap_pkg::ST_RESULT;
          oflow_d = total_q;
          count_d = '0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      nv_cfg_q <= 8'd2;
      count_q  <= '0;
      ov_q     <= 1'b0;
      total_q  <= '0;
      vis_q    <= '0;
    end else begin
      state_q  <= state_d;
      if (cfg_we_i) begin
        nv_cfg_q <= cfg_wdata_i;
      end
      count_q  <= count_d;
      ov_q     <= ov_d;
      total_q  <= total_d;
      vis_q    <= vis_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    nv_q    <= nv_d;
    thr_q   <= thr_d;
    top_q   <= top_d;
    cur_v_q <= cur_v_d;
    cur_n_q <= cur_n_d;
    cur_e_q <= cur_e_d;
    cur_b_q <= cur_b_d;
    e_q     <= e_d;
    k_q     <= k_d;
    b_q     <= b_d;
    ost_q   <= ost_d;
    oflow_q <= oflow_d;
  end

  assign out_o.valid    = ov_q;
  assign out_o.status   = ost_q;
  assign out_o.max_flow = oflow_q;

  mfap_edge_store #(
    .MAX_EDGES (MAX_EDGES),
    .CAP_WIDTH (CAP_WIDTH),
    .EW        (EW)
  ) u_edges (
    .clk_i        (clk_i),
    .ctl_i        (ectl),
    .waddr_i      (EW'(count_q)),
    .tail_i       (in_i.edge_tail),
    .head_i       (in_i.edge_head),
    .cap_i        (CAP_WIDTH'(in_i.edge_capacity)),
    .flow_waddr_i ((state_q == S_UW) ? sr_e : EW'(count_q)),
    .flow_i       ((state_q == S_UW) ? alu_flow : '0),
    .raddr_i      (e_raddr),
    .tail_o       (rd_tail),
    .head_o       (rd_head),
    .cap_o        (rd_cap),
    .flow_o       (rd_flow)
  );

  mfap_search_stack #(
    .DEPTH (MAX_VERTICES),
    .AW    (VW),
    .SW    (SW)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .re_i    (s_re),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  mfap_alu #(
    .CAP_WIDTH (CAP_WIDTH)
  ) u_alu (
    .cap_i   (rd_cap),
    .flow_i  (rd_flow),
    .back_i  (alu_back),
    .thr_i   (thr_q),
    .bneck_i (b_q),
    .pass_o  (alu_pass),
    .min_o   (alu_min),
    .flow_o  (alu_flow)
  );

  // The edge count never passes the store size.
  `MFAP_ASSERT(a_count_bound, 32'(count_q) <= MAX_EDGES)
  // A finished solve always leaves a result pending.
  `MFAP_ASSERT(a_done_result, (state_q == S_DONE) && out_free |=> ov_q && ost_q == mfap_pkg::ST_RESULT)
  // The search never descends deeper than the vertices in use.
  `MFAP_NEVER(a_stack_depth, (state_q == S_CHECK) && (32'(top_q) >= 32'(nv_q)))
  // The source is always marked during a search.
  `MFAP_NEVER(a_source_mark, (state_q == S_EDGE) && !vis_q[0])
endmodule
`default_nettype wire
